>>> sv/mch64_pkg.sv
// ---------------------------------------------------------------------------
// mch64_pkg
// constants and types shared by the 64-bit machine code hash block
// ---------------------------------------------------------------------------
package mch64_pkg;

  // per-character mixing constants
  localparam logic [7:0] XOR_ADD   = 8'h0a;
  localparam logic [7:0] SUM_MASK  = 8'h7e;
  localparam logic [7:0] QUAD_MASK = 8'h4e;

  // modulo-6 counter length; the counter wraps after MOD6_TOP
  localparam int unsigned MOD6_LEN = 6;
  localparam logic [2:0]  MOD6_TOP = 3'(MOD6_LEN - 1);

  // cleared value of the quadratic accumulator
  localparam logic [7:0] QUAD_INIT = 8'h01;

  localparam int unsigned CODE_W = 64;

  // accumulator and counter set
  typedef struct packed {
    logic [7:0] acc_xor;
    logic [7:0] acc_sum;
    logic [7:0] acc_neg;
    logic [7:0] acc_rotl;
    logic [7:0] acc_rotr;
    logic [7:0] acc_quad;
    logic [7:0] acc_mass;
    logic [7:0] acc_other;
    logic [7:0] position;
    logic [2:0] position_mod6;
  } hash_state_t;

  localparam hash_state_t STATE_CLEAR = '{
    acc_xor:       8'h00,
    acc_sum:       8'h00,
    acc_neg:       8'h00,
    acc_rotl:      8'h00,
    acc_rotr:      8'h00,
    acc_quad:      QUAD_INIT,
    acc_mass:      8'h00,
    acc_other:     8'h00,
    position:      8'h00,
    position_mod6: 3'd0
  };

endpackage

>>> sv/machine_code_hash64.sv
// ---------------------------------------------------------------------------
// machine_code_hash64
// streaming 64-bit hash over a string, one character per beat
// ---------------------------------------------------------------------------
// usage
//   slave side: one character per beat in s_tdata[7:0]; s_tuser marks the
//   first character of a string (accumulators and counters are cleared
//   before it is absorbed), s_tlast marks the final character
//   master side: one 64-bit code beat per string, sent after the beat that
//   carried s_tlast; bytes msb first are rotr, quad, sum, rotl, mass, xor,
//   other, neg
// throughput and latency
//   one character per clock while s_tready is high; the whole accumulator
//   update is a single combinational pass (two 8x8 multipliers in parallel
//   feed the mass and other terms) written straight into the state registers
//   the code appears on m_tvalid in the cycle after the last beat is taken
// stall behavior
//   the code sits in an output register; s_tready stays high while that
//   register is empty or being drained in the same cycle, so a held result
//   stalls the input only while m_tready is low
// reset
//   rst (synchronous, active high) clears the accumulators to their string
//   start values and drops m_tvalid; the first string after reset, even
//   without a first mark, starts from those same values
// ---------------------------------------------------------------------------
module machine_code_hash64 (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic        s_tuser,   // [0] first
  input  logic        s_tlast,   // last character of the string
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // [7:0] neg, [15:8] other, [23:16] xor,
                                 // [31:24] mass, [39:32] rotl, [47:40] sum,
                                 // [55:48] quad, [63:56] rotr
);

  mch64_pkg::hash_state_t st;       // registered accumulators
  mch64_pkg::hash_state_t base;     // state after optional clear
  mch64_pkg::hash_state_t st_next;

  logic        s_beat;
  logic [7:0]  ch;
  logic [4:0]  rot_amt;
  logic [63:0] ch_dbl;
  logic [63:0] rotl_wide;
  logic [63:0] rotr_wide;
  logic [15:0] ch_sq;
  logic [15:0] mass_prod;
  logic [15:0] other_prod;

  assign s_tready = !m_tvalid || m_tready;
  assign s_beat   = s_tvalid && s_tready;
  assign ch       = s_tdata;

  // first mark restarts the string
  assign base = s_tuser ? mch64_pkg::STATE_CLEAR : st;

  // 32-bit rotations of the zero-extended character by position mod 32
  assign rot_amt   = base.position[4:0];
  assign ch_dbl    = {24'h0, ch, 24'h0, ch};
  assign rotl_wide = ch_dbl >> (6'd32 - {1'b0, rot_amt});
  assign rotr_wide = ch_dbl >> {1'b0, rot_amt};
  assign ch_sq     = ch * ch;

  always_comb begin
    st_next = base;
    st_next.acc_xor  = base.acc_xor ^ (ch + mch64_pkg::XOR_ADD);
    st_next.acc_sum  = base.acc_sum + (ch & mch64_pkg::SUM_MASK);
    st_next.acc_neg  = base.acc_neg - ch;
    st_next.acc_rotl = base.acc_rotl + rotl_wide[7:0];
    st_next.acc_rotr = base.acc_rotr + rotr_wide[7:0];
    st_next.acc_quad = base.acc_quad + ch_sq[7:0] + {ch[6:0], 1'b0} + ch
                       - base.position;
    // both products use the freshly updated accumulators
    mass_prod  = st_next.acc_rotl * st_next.acc_rotr;
    other_prod = st_next.acc_neg * st_next.acc_sum;
    st_next.acc_mass = base.acc_mass + ch + (st_next.acc_sum ^ st_next.acc_xor)
                       + mass_prod[7:0];
    st_next.acc_other = base.acc_other + other_prod[7:0]
                        + {st_next.acc_mass[6:0], 1'b0}
                        + {5'h0, base.position_mod6}
                        + (st_next.acc_quad & mch64_pkg::QUAD_MASK);
    st_next.position = base.position + 8'd1;
    st_next.position_mod6 = (base.position_mod6 >= mch64_pkg::MOD6_TOP) ? 3'd0
                            : base.position_mod6 + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= mch64_pkg::STATE_CLEAR;
    end else if (s_beat) begin
      st <= st_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_beat && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_beat && s_tlast) begin
      m_tdata <= {st_next.acc_rotr, st_next.acc_quad, st_next.acc_sum,
                  st_next.acc_rotl, st_next.acc_mass, st_next.acc_xor,
                  st_next.acc_other, st_next.acc_neg};
    end
  end

  // checks
  a_mod6_range: assert property (@(posedge clk) disable iff (rst)
    st.position_mod6 <= mch64_pkg::MOD6_TOP)
    else $error("mod6 counter out of range");

  a_last_gives_code: assert property (@(posedge clk) disable iff (rst)
    s_beat && s_tlast |=> m_tvalid)
    else $error("last beat produced no code");

  a_first_restarts: assert property (@(posedge clk) disable iff (rst)
    s_beat && s_tuser |=> st.position == 8'd1 && st.position_mod6 == 3'd1)
    else $error("first beat did not restart counters");

  a_position_steps: assert property (@(posedge clk) disable iff (rst)
    s_beat && !s_tuser |=> st.position == $past(st.position) + 8'd1)
    else $error("position did not advance");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !s_beat |=> st == $past(st))
    else $error("state changed without a beat");

endmodule
